### hdl/particle_ring_update_macros.svh
// Assertion macros shared by the particle ring RTL.
`ifndef PARTICLE_RING_UPDATE_MACROS_SVH
`define PARTICLE_RING_UPDATE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PRU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pru_pkg.sv
// Package with types, codes and arithmetic helpers of the particle ring.
package pru_pkg;

	localparam int MAX_SLOTS_DEF = 64;
	localparam int FRAC_BITS = 16;
	localparam logic signed [31:0] MIN_LIFE = 32'sd655;

	localparam logic [1:0] OP_EMIT  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] life;
		logic signed [31:0] age;
		logic signed [31:0] scale_begin;
		logic signed [31:0] scale_end;
		logic signed [31:0] scale_now;
	} slot_entry_t;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [47:0] b);
		logic signed [48:0] s;
		s = 49'(a) + 49'(b);
		if (s > 49'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (s < -49'sd2147483648) begin
			return 32'sh80000000;
		end
		return s[31:0];
	endfunction

endpackage

### hdl/pru_ifs.sv
// Valid/ready channel interfaces for the particle ring requests and results.
interface pru_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;
	logic signed [31:0] lifetime;
	logic signed [31:0] scale_begin;
	logic signed [31:0] scale_end;
	logic signed [31:0] time_step;

	modport source (output valid, operation, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		lifetime, scale_begin, scale_end, time_step, input ready);
	modport sink (input valid, operation, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		lifetime, scale_begin, scale_end, time_step, output ready);
endinterface

interface pru_rsp_if;
	logic              valid;
	logic              ready;
	logic [5:0]        slot;
	logic signed [31:0] out_pos_x;
	logic signed [31:0] out_pos_y;
	logic signed [31:0] out_pos_z;
	logic [30:0]       out_scale;
	logic              out_active;
	logic [6:0]        active_count;
	logic              last;

	modport source (output valid, slot, out_pos_x, out_pos_y, out_pos_z, out_scale,
		out_active, active_count, last, input ready);
	modport sink (input valid, slot, out_pos_x, out_pos_y, out_pos_z, out_scale,
		out_active, active_count, last, output ready);
endinterface

### hdl/particle_ring_update.sv
// Particle ring top level: slot memory with a read-modify-write sequencer.
// Emit, clear: done on acceptance. Query: walks the slots in use and gives one result.
// Tick with a time step above zero: read and age each slot, and for a live slot the
// 16-step remainder divider, scale and write-back; then a result per slot from memory.
// A new item is taken only after the last result of the previous one has transferred.
// Reset: all slots read as zero, nothing alive, spawn index 0, slots in use 64.
`include "particle_ring_update_macros.svh"

module particle_ring_update
	import pru_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pru_req_if.sink    req,
	pru_rsp_if.source  rsp,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata
);

	localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam logic [6:0] MAX_N = 7'(MAX_SLOTS);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_TRD  = 4'd1;
	localparam logic [3:0] ST_TAGE = 4'd2;
	localparam logic [3:0] ST_TDIV = 4'd3;
	localparam logic [3:0] ST_TSCL = 4'd4;
	localparam logic [3:0] ST_TWB  = 4'd5;
	localparam logic [3:0] ST_ORD  = 4'd6;
	localparam logic [3:0] ST_OLD  = 4'd7;
	localparam logic [3:0] ST_OSND = 4'd8;
	localparam logic [3:0] ST_QCNT = 4'd9;

	slot_entry_t mem [MAX_SLOTS];
	slot_entry_t rd_q;
	logic        rd_hit_q;
	slot_entry_t entry;
	slot_entry_t aged;
	slot_entry_t ent_q;
	slot_entry_t wr_data;
	logic        wr_en;
	logic [IW-1:0] wr_addr;

	logic [3:0]  state_q;
	logic [6:0]  slots_in_use_q;
	logic [6:0]  n_w;
	logic [IW-1:0] spawn_q;
	logic [IW-1:0] emit_idx;
	logic [MAX_SLOTS-1:0] alive_q;
	logic [MAX_SLOTS-1:0] written_q;
	logic [6:0]  i_q;
	logic [IW-1:0] idx;
	logic        at_end;
	logic [6:0]  cnt_q;
	logic signed [31:0] dt_q;
	logic [3:0]  k_q;
	logic [31:0] rem_q;
	logic [15:0] quo_q;
	logic signed [63:0] mul_q;
	logic signed [49:0] prod_q;
	logic [32:0] rem_sh;
	logic [32:0] life_ext;
	logic signed [31:0] vel_sel;
	logic signed [31:0] age_new;
	logic signed [32:0] diff;
	logic signed [34:0] scale_sum;
	logic signed [31:0] scale_new;
	logic        accept;

	logic        out_valid_q;
	logic [5:0]  out_slot_q;
	logic signed [31:0] out_px_q;
	logic signed [31:0] out_py_q;
	logic signed [31:0] out_pz_q;
	logic [30:0] out_scale_q;
	logic        out_active_q;
	logic [6:0]  out_count_q;
	logic        out_last_q;

	always_comb begin
		if (slots_in_use_q == 7'd0) begin
			n_w = 7'd1;
		end else if (slots_in_use_q > MAX_N) begin
			n_w = MAX_N;
		end else begin
			n_w = slots_in_use_q;
		end
	end

	assign idx = i_q[IW-1:0];
	assign at_end = (i_q == n_w - 7'd1);
	assign emit_idx = (7'(spawn_q) >= n_w) ? '0 : spawn_q;
	assign req.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign accept = req.valid && req.ready;

	assign entry = rd_hit_q ? rd_q : '0;
	assign age_new = sat_add(entry.age, 48'(dt_q));
	assign rem_sh = {rem_q, 1'b0};
	assign life_ext = {1'b0, ent_q.life};
	assign diff = 33'(ent_q.scale_end) - 33'(ent_q.scale_begin);
	assign scale_sum = 35'(ent_q.scale_begin) + 35'($signed(prod_q[49:16]));

	always_comb begin
		aged = entry;
		aged.age = age_new;
	end

	always_comb begin
		unique case (k_q[1:0])
			2'd0: vel_sel = ent_q.vel_x;
			2'd1: vel_sel = ent_q.vel_y;
			default: vel_sel = ent_q.vel_z;
		endcase
	end

	always_comb begin
		if (scale_sum < 35'sd0) begin
			scale_new = 32'sd0;
		end else if (scale_sum > 35'sd2147483647) begin
			scale_new = 32'sh7fffffff;
		end else begin
			scale_new = scale_sum[31:0];
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx;
		wr_data = ent_q;
		wr_data.scale_now = scale_new;
		if (accept && req.operation == OP_EMIT) begin
			wr_en = 1'b1;
			wr_addr = emit_idx;
			wr_data.pos_x = req.pos_x;
			wr_data.pos_y = req.pos_y;
			wr_data.pos_z = req.pos_z;
			wr_data.vel_x = req.vel_x;
			wr_data.vel_y = req.vel_y;
			wr_data.vel_z = req.vel_z;
			wr_data.life = (req.lifetime < MIN_LIFE) ? MIN_LIFE : req.lifetime;
			wr_data.age = 32'sd0;
			wr_data.scale_begin = (req.scale_begin < 32'sd0) ? 32'sd0 : req.scale_begin;
			wr_data.scale_end = (req.scale_end < 32'sd0) ? 32'sd0 : req.scale_end;
			wr_data.scale_now = wr_data.scale_begin;
		end else if (state_q == ST_TWB) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= 7'd64;
		end else if (cfg_we) begin
			slots_in_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_TAGE: begin
				ent_q <= aged;
				rem_q <= age_new;
				quo_q <= '0;
				k_q <= '0;
			end
			ST_TDIV: begin
				if (rem_sh >= life_ext) begin
					rem_q <= 32'(rem_sh - life_ext);
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					quo_q <= {quo_q[14:0], 1'b0};
				end
				k_q <= k_q + 4'd1;
				if (k_q < 4'd3) begin
					mul_q <= vel_sel * dt_q;
				end
				if (k_q == 4'd1) begin
					ent_q.pos_x <= sat_add(ent_q.pos_x, $signed(mul_q[63:16]));
				end
				if (k_q == 4'd2) begin
					ent_q.pos_y <= sat_add(ent_q.pos_y, $signed(mul_q[63:16]));
				end
				if (k_q == 4'd3) begin
					ent_q.pos_z <= sat_add(ent_q.pos_z, $signed(mul_q[63:16]));
				end
			end
			ST_TSCL: begin
				prod_q <= diff * $signed({1'b0, quo_q});
			end
			default: begin
			end
		endcase
		if (accept) begin
			dt_q <= req.time_step;
		end
		if (state_q == ST_OLD) begin
			out_slot_q <= 6'(i_q);
			out_px_q <= entry.pos_x;
			out_py_q <= entry.pos_y;
			out_pz_q <= entry.pos_z;
			out_scale_q <= entry.scale_now[30:0];
			out_active_q <= alive_q[idx];
			out_count_q <= cnt_q;
			out_last_q <= at_end;
		end else if (state_q == ST_QCNT && at_end) begin
			out_slot_q <= '0;
			out_px_q <= '0;
			out_py_q <= '0;
			out_pz_q <= '0;
			out_scale_q <= '0;
			out_active_q <= 1'b0;
			out_count_q <= cnt_q + 7'(alive_q[idx]);
			out_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			spawn_q <= '0;
			alive_q <= '0;
			written_q <= '0;
			i_q <= '0;
			cnt_q <= '0;
			rd_hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_hit_q <= written_q[idx];
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						i_q <= '0;
						cnt_q <= '0;
						unique case (req.operation)
							OP_EMIT: begin
								alive_q[emit_idx] <= 1'b1;
								written_q[emit_idx] <= 1'b1;
								spawn_q <= (7'(emit_idx) + 7'd1 == n_w) ? '0 : emit_idx + IW'(1);
							end
							OP_TICK: begin
								if (req.time_step > 32'sd0) begin
									state_q <= ST_TRD;
								end
							end
							OP_CLEAR: begin
								alive_q <= '0;
								written_q <= '0;
								spawn_q <= '0;
							end
							default: begin
								state_q <= ST_QCNT;
							end
						endcase
					end
				end
				ST_TRD: begin
					state_q <= ST_TAGE;
				end
				ST_TAGE: begin
					if (alive_q[idx] && age_new < entry.life) begin
						cnt_q <= cnt_q + 7'd1;
						state_q <= ST_TDIV;
					end else begin
						if (alive_q[idx]) begin
							alive_q[idx] <= 1'b0;
						end
						i_q <= at_end ? 7'd0 : i_q + 7'd1;
						state_q <= at_end ? ST_ORD : ST_TRD;
					end
				end
				ST_TDIV: begin
					if (k_q == 4'(FRAC_BITS - 1)) begin
						state_q <= ST_TSCL;
					end
				end
				ST_TSCL: begin
					state_q <= ST_TWB;
				end
				ST_TWB: begin
					i_q <= at_end ? 7'd0 : i_q + 7'd1;
					state_q <= at_end ? ST_ORD : ST_TRD;
				end
				ST_ORD: begin
					state_q <= ST_OLD;
				end
				ST_OLD: begin
					out_valid_q <= 1'b1;
					state_q <= ST_OSND;
				end
				ST_QCNT: begin
					if (alive_q[idx]) begin
						cnt_q <= cnt_q + 7'd1;
					end
					if (at_end) begin
						out_valid_q <= 1'b1;
						state_q <= ST_OSND;
					end else begin
						i_q <= i_q + 7'd1;
					end
				end
				ST_OSND: begin
					if (rsp.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + 7'd1;
							state_q <= ST_ORD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.slot = out_slot_q;
	assign rsp.out_pos_x = out_px_q;
	assign rsp.out_pos_y = out_py_q;
	assign rsp.out_pos_z = out_pz_q;
	assign rsp.out_scale = out_scale_q;
	assign rsp.out_active = out_active_q;
	assign rsp.active_count = out_count_q;
	assign rsp.last = out_last_q;

	`PRU_ASSERT_SAME(a_div_rem, state_q == ST_TDIV, rem_q < ent_q.life, "divider remainder not below life")
	`PRU_ASSERT_SAME(a_count_bound, rsp.valid, rsp.active_count <= n_w, "active count above slots in use")
	`PRU_ASSERT_SAME(a_busy_no_accept, state_q != ST_IDLE, !req.ready, "request taken while busy")
	`PRU_ASSERT_NEXT(a_write_after_scale, state_q == ST_TSCL, state_q == ST_TWB && wr_en, "slot write-back missing")

endmodule

### bench/particle_ring_update_tb.sv
// Self-checking testbench of the particle ring: directed table, then random phases.
module particle_ring_update_tb;
	import pru_pkg::*;

	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] px, py, pz, vx, vy, vz;
		logic signed [31:0] life, sb, se, dt;
		int                 want_count;
	} ring_item_t;

	typedef struct {
		logic [5:0]         slot;
		logic signed [31:0] px, py, pz;
		logic [30:0]        scale;
		logic               active;
		logic [6:0]         count;
		logic               last;
	} slot_report_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [6:0] cfg_wdata = 0;

	pru_req_if req();
	pru_rsp_if rsp();

	particle_ring_update dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	slot_report_t reports_due[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	// Mirror of the ring.
	logic [6:0]         m_slots_reg = 7'd64;
	int                 m_spawn = 0;
	logic signed [31:0] m_pos[64][3];
	logic signed [31:0] m_vel[64][3];
	logic signed [31:0] m_life[64], m_age[64], m_sb[64], m_se[64], m_snow[64];
	logic               m_alive[64];

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic int used_slots();
		if (m_slots_reg < 1) return 1;
		if (m_slots_reg > 64) return 64;
		return int'(m_slots_reg);
	endfunction

	function automatic int alive_count(int n);
		int c;
		c = 0;
		for (int i = 0; i < n; i++) if (m_alive[i]) c++;
		return c;
	endfunction

	function automatic void wipe_ring();
		for (int i = 0; i < 64; i++) begin
			for (int a = 0; a < 3; a++) begin
				m_pos[i][a] = 0;
				m_vel[i][a] = 0;
			end
			m_life[i] = 0; m_age[i] = 0; m_sb[i] = 0; m_se[i] = 0; m_snow[i] = 0;
			m_alive[i] = 0;
		end
		m_spawn = 0;
	endfunction

	function automatic void age_slot(int i, logic signed [31:0] dt);
		longint t, s;
		if (!m_alive[i]) return;
		m_age[i] = clamp32(longint'(m_age[i]) + longint'(dt));
		if (m_age[i] >= m_life[i]) begin
			m_alive[i] = 0;
			return;
		end
		for (int a = 0; a < 3; a++)
			m_pos[i][a] = clamp32(longint'(m_pos[i][a]) +
				((longint'(m_vel[i][a]) * longint'(dt)) >>> 16));
		if (m_life[i] > 0 && m_age[i] > 0)
			t = (longint'(m_age[i]) <<< 16) / longint'(m_life[i]);
		else
			t = 0;
		if (t > 65536) t = 65536;
		s = longint'(m_sb[i]) + (((longint'(m_se[i]) - longint'(m_sb[i])) * t) >>> 16);
		if (s < 0) s = 0;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		m_snow[i] = s[31:0];
	endfunction

	function automatic void predict_ring(ring_item_t it);
		int n, i, cnt;
		slot_report_t r;
		n = used_slots();
		case (it.op)
			OP_EMIT: begin
				i = (m_spawn >= n) ? 0 : m_spawn;
				m_pos[i][0] = it.px; m_pos[i][1] = it.py; m_pos[i][2] = it.pz;
				m_vel[i][0] = it.vx; m_vel[i][1] = it.vy; m_vel[i][2] = it.vz;
				m_life[i] = (it.life < MIN_LIFE) ? MIN_LIFE : it.life;
				m_age[i] = 0;
				m_sb[i] = (it.sb < 0) ? 0 : it.sb;
				m_se[i] = (it.se < 0) ? 0 : it.se;
				m_snow[i] = m_sb[i];
				m_alive[i] = 1;
				m_spawn = (i + 1) % n;
			end
			OP_TICK: begin
				if (it.dt > 0) begin
					for (int k = 0; k < n; k++) age_slot(k, it.dt);
					cnt = alive_count(n);
					for (int k = 0; k < n; k++) begin
						r.slot = k[5:0];
						r.px = m_pos[k][0]; r.py = m_pos[k][1]; r.pz = m_pos[k][2];
						r.scale = m_snow[k][30:0];
						r.active = m_alive[k];
						r.count = cnt[6:0];
						r.last = (k == n - 1);
						reports_due.push_back(r);
					end
				end
			end
			OP_CLEAR: wipe_ring();
			default: begin
				r = '{default: 0};
				cnt = (it.want_count >= 0) ? it.want_count : alive_count(n);
				r.count = cnt[6:0];
				r.last = 1;
				reports_due.push_back(r);
			end
		endcase
	endfunction

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			slot_report_t e;
			if (reports_due.size() == 0) begin
				$error("unexpected result transfer for slot %0d", rsp.slot);
				mismatches++;
			end else begin
				e = reports_due.pop_front();
				if (rsp.slot !== e.slot) begin
					$error("slot: expected %0d, got %0d", e.slot, rsp.slot); mismatches++;
				end
				if (rsp.out_pos_x !== e.px) begin
					$error("out_pos_x: expected %0d, got %0d", e.px, rsp.out_pos_x);
					mismatches++;
				end
				if (rsp.out_pos_y !== e.py) begin
					$error("out_pos_y: expected %0d, got %0d", e.py, rsp.out_pos_y);
					mismatches++;
				end
				if (rsp.out_pos_z !== e.pz) begin
					$error("out_pos_z: expected %0d, got %0d", e.pz, rsp.out_pos_z);
					mismatches++;
				end
				if (rsp.out_scale !== e.scale) begin
					$error("out_scale: expected %0d, got %0d", e.scale, rsp.out_scale);
					mismatches++;
				end
				if (rsp.out_active !== e.active) begin
					$error("out_active: expected %0d, got %0d", e.active, rsp.out_active);
					mismatches++;
				end
				if (rsp.active_count !== e.count) begin
					$error("active_count: expected %0d, got %0d", e.count, rsp.active_count);
					mismatches++;
				end
				if (rsp.last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, rsp.last); mismatches++;
				end
			end
		end
	end

	task automatic send_item(ring_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid = 0;
			@(posedge clk);
			@(negedge clk);
		end
		req.valid = 1;
		req.operation = it.op;
		req.pos_x = it.px; req.pos_y = it.py; req.pos_z = it.pz;
		req.vel_x = it.vx; req.vel_y = it.vy; req.vel_z = it.vz;
		req.lifetime = it.life; req.scale_begin = it.sb; req.scale_end = it.se;
		req.time_step = it.dt;
		do @(posedge clk); while (!req.ready);
		predict_ring(it);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req.valid = 0;
		while (reports_due.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_slots(logic [6:0] v);
		wait_drained();
		cfg_we = 1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 0;
		m_slots_reg = v;
	endtask

	function automatic ring_item_t mk(logic [1:0] op, logic signed [31:0] px,
		logic signed [31:0] vx, logic signed [31:0] life, logic signed [31:0] sb,
		logic signed [31:0] se, logic signed [31:0] dt, int want);
		ring_item_t it;
		it.op = op; it.px = px; it.py = -px; it.pz = px >>> 1;
		it.vx = vx; it.vy = -vx; it.vz = vx >>> 3;
		it.life = life; it.sb = sb; it.se = se; it.dt = dt; it.want_count = want;
		return it;
	endfunction

	function automatic logic signed [31:0] rnd_val(int small_max);
		if ($urandom_range(99) < 20) return $urandom;
		return $urandom_range(small_max) - small_max / 2;
	endfunction

	function automatic ring_item_t rnd_item(bit well_formed);
		ring_item_t it;
		int w;
		w = $urandom_range(99);
		it.op = well_formed ? ((w < 50) ? OP_EMIT : (w < 85) ? OP_TICK :
			(w < 97) ? OP_QUERY : OP_CLEAR) : 2'($urandom_range(3));
		it.px = rnd_val(1 << 24); it.py = rnd_val(1 << 24); it.pz = rnd_val(1 << 24);
		it.vx = rnd_val(1 << 20); it.vy = rnd_val(1 << 20); it.vz = rnd_val(1 << 20);
		it.life = ($urandom_range(99) < 15) ? $urandom : $urandom_range(16 << 16);
		it.sb = rnd_val(1 << 22); it.se = rnd_val(1 << 22);
		if (!well_formed || $urandom_range(99) < 10)
			it.dt = $urandom;
		else
			it.dt = $urandom_range(3 << 16, 1);
		it.want_count = -1;
		return it;
	endfunction

	ring_item_t plan[$];
	int idle_send[4] = '{0, 65, 0, 10};
	int idle_recv[4] = '{0, 0, 65, 10};
	logic [6:0] slot_choices[8] = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd0, 7'd100, 7'd64};

	initial begin
		req.valid = 0; req.operation = OP_QUERY;
		req.pos_x = 0; req.pos_y = 0; req.pos_z = 0;
		req.vel_x = 0; req.vel_y = 0; req.vel_z = 0;
		req.lifetime = 0; req.scale_begin = 0; req.scale_end = 0; req.time_step = 0;
		rsp.ready = 0;
		wipe_ring();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		plan.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 1, -1));
		plan.push_back(mk(OP_EMIT, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			-5, -7, 0, -1));
		plan.push_back(mk(OP_EMIT, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
			32'sh7fffffff, 0, 0, -1));
		plan.push_back(mk(OP_EMIT, 32'h10000, 32'h8000, 32'h40000, 0,
			32'sh7fffffff, 0, -1));
		plan.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 3));
		plan.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, -1));
		plan.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 32'sh80000000, -1));
		plan.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 1, -1));
		plan.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 32'h10000, -1));
		plan.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 32'sh7fffffff, -1));
		plan.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_EMIT, 32'h20000, -32'sh10000, 32'h30000, 32'h10000,
			32'h50000, 0, -1));
		plan.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, -1));
		plan.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 32'h8000, -1));
		foreach (plan[k]) send_item(plan[k]);

		// Spawn index past the new ring size, then the out-of-range register values.
		for (int k = 0; k < 6; k++) send_item(mk(OP_EMIT, k << 16, 32'h100, 32'h80000,
			32'h10000, 0, 0, -1));
		write_slots(7'd3);
		send_item(mk(OP_EMIT, 32'h70000, 32'h1000, 32'h80000, 0, 32'h10000, 0, -1));
		send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 32'h10000, -1));
		write_slots(7'd0);
		send_item(mk(OP_EMIT, 32'h1, 32'h1, 32'h1000, 0, 0, 0, -1));
		send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 32'h100, -1));
		write_slots(7'd127);
		send_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, -1));

		// Long receiver hold while the sender keeps offering.
		write_slots(7'd4);
		hold_cycles = 400;
		for (int k = 0; k < 6; k++) send_item(rnd_item(1));
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			write_slots(slot_choices[$urandom_range(7)]);
			send_idle_pct = idle_send[ph % 4];
			recv_stall_pct = idle_recv[ph % 4];
			for (int k = 0; k < 28; k++) send_item(rnd_item($urandom_range(99) < 85));
		end
		write_slots(7'd64);
		for (int k = 0; k < 6; k++) send_item(rnd_item(1));
		send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 32'h4000, -1));

		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#60000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

### filelist.f
+incdir+hdl
hdl/pru_pkg.sv
hdl/pru_ifs.sv
hdl/particle_ring_update.sv
bench/particle_ring_update_tb.sv
